// ===== design/wvsd_pkg.sv =====
// shared constants, types and sequencer states for the window variance detector
package wvsd_pkg;

  localparam int POS_W      = 24;
  localparam int THR_W      = 32;
  localparam int MUL_BW     = 32;
  localparam int COUNT_W    = 5;
  localparam int WINDOW_DEF = 30;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 8;

  localparam logic [THR_W-1:0] THR_RESET = 32'd1677722;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_SQ_NEW,
    ST_SQ_OLD,
    ST_UPDATE,
    ST_NQ,
    ST_SS,
    ST_DIV,
    ST_VSQ,
    ST_THR,
    ST_OUT
  } state_t;

endpackage

// ===== design/wvsd_ram.sv =====
// generic single write port ram with registered read
module wvsd_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/wvsd_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
module wvsd_mul #(
  parameter int AW = 52,
  parameter int BW = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] prod
);

  localparam int CW = $clog2(BW + 1);

  logic [AW+BW-1:0] prod_r, prod_nxt;
  logic [AW-1:0]    a_r;
  logic [CW-1:0]    cnt_r;
  logic             run_r, done_r;
  logic [AW:0]      part;

  assign part = {1'b0, prod_r[AW+BW-1:BW]} + (prod_r[0] ? {1'b0, a_r} : {(AW+1){1'b0}});
  assign prod_nxt = {part, prod_r[BW-1:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(BW);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= {{AW{1'b0}}, b};
      a_r    <= a;
    end else if (run_r) begin
      prod_r <= prod_nxt;
    end
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

// ===== design/wvsd_div.sv =====
// restoring divider, one quotient bit per cycle
module wvsd_div #(
  parameter int DW = 58,
  parameter int VW = 14
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quot
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quot_r;
  logic [VW-1:0] rem_r, div_r;
  logic [CW-1:0] cnt_r;
  logic          run_r, done_r;
  logic [VW:0]   trial, diff;
  logic          fits;

  assign trial = {rem_r, quot_r[DW-1]};
  assign fits  = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(DW);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      div_r  <= divisor;
    end else if (run_r) begin
      rem_r  <= fits ? diff[VW-1:0] : trial[VW-1:0];
      quot_r <= {quot_r[DW-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ===== design/window_variance_stability_detector_top.sv =====
// sliding window variance stability detector, sequencer and datapath
//
// channel | dir | handshake          | payload
// in_     | in  | in_tvalid/tready   | tdata: pos_x[23:0] pos_y[47:24] pos_z[71:48]
// out_    | out | out_tvalid/tready  | tdata: stable[0] sample_count[5:1]
// cfg_    | in  | cfg_valid/ready    | cfg_data: stability_threshold
//
// a sample is written to the ring, then each axis is squared and added to the sums,
// the oldest entry's square taken out once the window is full; a full window then
// takes n*q, s*s, a DW-bit divide (57 at 30) and a square per axis, then thr*thr.
// reset is synchronous, clears the counts and sums and loads THR_RESET; the ring ram
// needs no clearing since an entry's old value is used only after it was written.
// a new sample is taken while the previous result still waits on out_tready.
module window_variance_stability_detector_top #(
  parameter int WINDOW = wvsd_pkg::WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [wvsd_pkg::IN_DATA_W-1:0]   in_tdata,   // pos_x, pos_y, pos_z
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [wvsd_pkg::OUT_DATA_W-1:0]  out_tdata,  // stable, sample_count, zero fill
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wvsd_pkg::THR_W-1:0]       cfg_data
);

  import wvsd_pkg::*;

  localparam int IW  = $clog2(WINDOW);
  localparam int NW  = $clog2(WINDOW + 1);
  localparam int SW  = POS_W + $clog2(WINDOW);
  localparam int QW  = 2 * POS_W - 1 + $clog2(WINDOW);
  localparam int DW  = QW + NW;
  localparam int VW  = 2 * NW;
  localparam int AW  = QW;
  localparam int PW  = AW + MUL_BW;
  localparam int HW  = 3 * POS_W;
  localparam logic [VW-1:0] NSQ = VW'(WINDOW * WINDOW);

  state_t state_r, state_nxt;

  logic [HW-1:0]          pos_r;
  logic [THR_W-1:0]       thr_r;
  logic [NW-1:0]          fill_r, fill_upd;
  logic [IW-1:0]          widx_r;
  logic                   full_r, full_after;
  logic [1:0]             ax_r;
  logic                   issued_r;
  logic signed [SW-1:0]   s_r [3];
  logic [QW-1:0]          q_r [3];
  logic [2*POS_W-1:0]     sqv_r, sqo_r;
  logic [DW-1:0]          nq_r, d_r;
  logic [2*THR_W+1:0]     acc_r;
  logic                   bad_r, stable_r;
  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;

  logic                   in_xfer, slot_free;
  logic                   mul_start, mul_done, div_start, div_done;
  logic [AW-1:0]          mul_a;
  logic [MUL_BW-1:0]      mul_b;
  logic [PW-1:0]          mul_prod;
  logic [DW-1:0]          quot;
  logic                   quot_big;
  logic [HW-1:0]          old_all;
  logic signed [POS_W-1:0] v_cur, o_cur;
  logic [POS_W-1:0]       v_abs, o_abs;
  logic signed [SW-1:0]   s_cur;
  logic [SW-1:0]          s_abs;
  logic [DW-1:0]          ss_val;
  logic                   op_state, op_done;

  assign in_xfer   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  assign v_cur = signed'(pos_r[ax_r*POS_W +: POS_W]);
  assign o_cur = signed'(old_all[ax_r*POS_W +: POS_W]);
  assign v_abs = v_cur[POS_W-1] ? POS_W'(-v_cur) : POS_W'(v_cur);
  assign o_abs = o_cur[POS_W-1] ? POS_W'(-o_cur) : POS_W'(o_cur);
  assign s_cur = s_r[ax_r];
  assign s_abs = s_cur[SW-1] ? SW'(-s_cur) : SW'(s_cur);
  assign ss_val   = DW'(mul_prod);
  assign quot_big = |quot[DW-1:THR_W];

  assign fill_upd   = full_r ? fill_r : fill_r + 1'b1;
  assign full_after = fill_upd == NW'(WINDOW);

  wvsd_ram #(.DATA_W(HW), .DEPTH(WINDOW)) u_ring (
    .clk   (clk),
    .we    (state_r == ST_READ),
    .waddr (widx_r),
    .wdata (pos_r),
    .re    (in_xfer),
    .raddr (widx_r),
    .rdata (old_all)
  );

  wvsd_mul #(.AW(AW), .BW(MUL_BW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  wvsd_div #(.DW(DW), .VW(VW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (d_r),
    .divisor  (NSQ),
    .done     (div_done),
    .quot     (quot)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_xfer) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_SQ_NEW;
      ST_SQ_NEW: if (mul_done) state_nxt = full_r ? ST_SQ_OLD : ST_UPDATE;
      ST_SQ_OLD: if (mul_done) state_nxt = ST_UPDATE;
      ST_UPDATE: begin
        if (ax_r != 2'd2) state_nxt = ST_SQ_NEW;
        else state_nxt = full_after ? ST_NQ : ST_OUT;
      end
      ST_NQ:     if (mul_done) state_nxt = ST_SS;
      ST_SS:     if (mul_done) state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          if (!quot_big) state_nxt = ST_VSQ;
          else state_nxt = (ax_r == 2'd2) ? ST_THR : ST_NQ;
        end
      end
      ST_VSQ:    if (mul_done) state_nxt = (ax_r == 2'd2) ? ST_THR : ST_NQ;
      ST_THR:    if (mul_done) state_nxt = ST_OUT;
      ST_OUT:    if (slot_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // unit control and operand selection
  always_comb begin
    in_tready = 1'b0;
    op_state  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_SQ_NEW: begin
        op_state = 1'b1;
        mul_a    = AW'(v_abs);
        mul_b    = MUL_BW'(v_abs);
      end
      ST_SQ_OLD: begin
        op_state = 1'b1;
        mul_a    = AW'(o_abs);
        mul_b    = MUL_BW'(o_abs);
      end
      ST_NQ: begin
        op_state = 1'b1;
        mul_a    = AW'(q_r[ax_r]);
        mul_b    = MUL_BW'(WINDOW);
      end
      ST_SS: begin
        op_state = 1'b1;
        mul_a    = AW'(s_abs);
        mul_b    = MUL_BW'(s_abs);
      end
      ST_DIV:    op_state = 1'b1;
      ST_VSQ: begin
        op_state = 1'b1;
        mul_a    = AW'(quot[THR_W-1:0]);
        mul_b    = quot[THR_W-1:0];
      end
      ST_THR: begin
        op_state = 1'b1;
        mul_a    = AW'(thr_r);
        mul_b    = thr_r;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign op_done   = mul_done || div_done;
  assign mul_start = op_state && !issued_r && (state_r != ST_DIV);
  assign div_start = op_state && !issued_r && (state_r == ST_DIV);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      thr_r       <= THR_RESET;
      fill_r      <= '0;
      widx_r      <= '0;
      ax_r        <= '0;
      out_valid_r <= 1'b0;
      s_r         <= '{default: '0};
      q_r         <= '{default: '0};
    end else begin
      state_r  <= state_nxt;
      issued_r <= op_state && !op_done;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
      if (state_r == ST_OUT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_UPDATE: begin
          s_r[ax_r] <= s_cur + SW'(v_cur) - (full_r ? SW'(o_cur) : SW'(0));
          q_r[ax_r] <= q_r[ax_r] + QW'(sqv_r) - QW'(sqo_r);
          if (ax_r == 2'd2) begin
            ax_r   <= '0;
            fill_r <= fill_upd;
            widx_r <= (widx_r == IW'(WINDOW - 1)) ? '0 : widx_r + 1'b1;
          end else begin
            ax_r <= ax_r + 1'b1;
          end
        end
        ST_DIV: begin
          if (div_done && quot_big) begin
            ax_r <= (ax_r == 2'd2) ? 2'd0 : ax_r + 1'b1;
          end
        end
        ST_VSQ: begin
          if (mul_done) begin
            ax_r <= (ax_r == 2'd2) ? 2'd0 : ax_r + 1'b1;
          end
        end
        default: begin
          ax_r <= ax_r;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pos_r  <= in_tdata;
      full_r <= fill_r == NW'(WINDOW);
      acc_r  <= '0;
      bad_r  <= 1'b0;
      sqo_r  <= '0;
    end
    case (state_r)
      ST_SQ_NEW: if (mul_done) sqv_r <= mul_prod[2*POS_W-1:0];
      ST_SQ_OLD: if (mul_done) sqo_r <= mul_prod[2*POS_W-1:0];
      ST_UPDATE: stable_r <= 1'b0;
      ST_NQ:     if (mul_done) nq_r <= DW'(mul_prod);
      ST_SS:     if (mul_done) d_r <= (nq_r > ss_val) ? nq_r - ss_val : '0;
      ST_DIV:    if (div_done && quot_big) bad_r <= 1'b1;
      ST_VSQ:    if (mul_done) acc_r <= acc_r + (2*THR_W+2)'(mul_prod[2*THR_W-1:0]);
      ST_THR: begin
        if (mul_done) begin
          stable_r <= !bad_r && (acc_r < (2*THR_W+2)'(mul_prod[2*THR_W-1:0]));
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          out_data_r <= OUT_DATA_W'({COUNT_W'(fill_r), stable_r});
        end
      end
      default: begin
        stable_r <= stable_r;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== tb/window_variance_stability_detector_top_test.sv =====
// self-checking testbench for the window variance stability detector top
module window_variance_stability_detector_top_test;
  import wvsd_pkg::*;

  localparam int WIN        = WINDOW_DEF;
  localparam int HALF_CLK   = 6;
  localparam int STALL_LIM  = 40000;
  localparam int LONG_HOLD  = 3000;
  localparam int DRAIN_WAIT = 1000;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_z;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_x;
  } sample_t;

  typedef struct packed {
    logic [COUNT_W-1:0] sample_count;
    logic               stable;
  } verdict_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [THR_W-1:0]      cfg_data;

  window_variance_stability_detector_top #(.WINDOW(WIN)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // pos_x, pos_y, pos_z
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // stable, sample_count, zero fill
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  sample_t  pending_samples[$];
  verdict_t expected_verdicts[$];
  int       error_count = 0;
  int       results_seen = 0;
  int       quiet_cycles = 0;
  bit       no_idle = 0;

  // window model
  logic signed [POS_W-1:0] ring_x[WIN];
  logic signed [POS_W-1:0] ring_y[WIN];
  logic signed [POS_W-1:0] ring_z[WIN];
  int                      held = 0;
  int                      slot = 0;
  longint                  sum_x = 0, sum_y = 0, sum_z = 0;
  logic [63:0]             sq_x = '0, sq_y = '0, sq_z = '0;
  logic [THR_W-1:0]        threshold;

  function automatic logic [63:0] axis_variance(longint s, logic [63:0] q);
    logic [63:0] mag;
    logic [63:0] nq;
    logic [63:0] ss;
    mag = (s < 0) ? -s : s;
    nq  = 64'(WIN) * q;
    ss  = mag * mag;
    return ((nq > ss) ? nq - ss : 64'd0) / 64'(WIN * WIN);
  endfunction

  function automatic logic [63:0] square_mag(logic signed [POS_W-1:0] v);
    logic [63:0] a;
    a = (v < 0) ? -64'(signed'(v)) : 64'(signed'(v));
    return a * a;
  endfunction

  task automatic take_sample(input sample_t smp, output verdict_t res);
    logic [63:0] vx, vy, vz;
    logic [65:0] norm_sq;
    logic [65:0] thr_sq;
    if (held >= WIN) begin
      sum_x -= ring_x[slot]; sq_x -= square_mag(ring_x[slot]);
      sum_y -= ring_y[slot]; sq_y -= square_mag(ring_y[slot]);
      sum_z -= ring_z[slot]; sq_z -= square_mag(ring_z[slot]);
    end else begin
      held++;
    end
    ring_x[slot] = smp.pos_x; sum_x += smp.pos_x; sq_x += square_mag(smp.pos_x);
    ring_y[slot] = smp.pos_y; sum_y += smp.pos_y; sq_y += square_mag(smp.pos_y);
    ring_z[slot] = smp.pos_z; sum_z += smp.pos_z; sq_z += square_mag(smp.pos_z);
    slot = (slot + 1 >= WIN) ? 0 : slot + 1;
    res.sample_count = held[COUNT_W-1:0];
    res.stable = 1'b0;
    if (held >= WIN) begin
      vx = axis_variance(sum_x, sq_x);
      vy = axis_variance(sum_y, sq_y);
      vz = axis_variance(sum_z, sq_z);
      // a variance of 2^32 or more can never be stable
      if (vx[63:32] == 0 && vy[63:32] == 0 && vz[63:32] == 0) begin
        norm_sq = 66'(vx * vx) + 66'(vy * vy) + 66'(vz * vz);
        thr_sq  = 66'(64'(threshold) * 64'(threshold));
        res.stable = (norm_sq < thr_sq);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    error_count++;
  endtask

  initial begin
    clk = 1'b0;
    forever #HALF_CLK clk = ~clk;
  end

  // sender
  int send_gap = 0;
  always @(posedge clk) begin
    verdict_t res;
    sample_t  nxt;
    logic     nxt_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      nxt_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        take_sample(sample_t'(in_tdata), res);
        expected_verdicts = {expected_verdicts, res};
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 13) - 1;
        end else if (pending_samples.size() > 0) begin
          nxt = pending_samples[0];
          pending_samples.delete(0);
          in_tdata  <= nxt;
          nxt_valid = 1'b1;
        end
      end
      in_tvalid <= nxt_valid;
    end
  end

  // receiver, with one long hold-off to back the block up
  int  recv_stall = 0;
  bit  held_off = 0;
  always @(posedge clk) begin
    verdict_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = verdict_t'(out_tdata[COUNT_W:0]);
        if (expected_verdicts.size() == 0) begin
          report_mismatch("unexpected transfer", int'(out_tdata), -1);
        end else begin
          want = expected_verdicts[0];
          expected_verdicts.delete(0);
          if (got.stable !== want.stable)
            report_mismatch("stable", got.stable, want.stable);
          if (got.sample_count !== want.sample_count)
            report_mismatch("sample_count", got.sample_count, want.sample_count);
          if (out_tdata[OUT_DATA_W-1:COUNT_W+1] !== '0)
            report_mismatch("fill bits", out_tdata[OUT_DATA_W-1:COUNT_W+1], 0);
        end
        results_seen++;
      end
      if (!held_off && results_seen == 50) begin
        held_off = 1;
        recv_stall = LONG_HOLD;
      end else if (recv_stall == 0 && !no_idle && $urandom_range(0, 7) == 0) begin
        recv_stall = $urandom_range(1, 13);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIM) begin
      $display("window_variance_stability_detector_top verification failed");
      $finish;
    end
  end

  task automatic write_threshold(input logic [THR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    threshold = value;
  endtask

  task automatic wait_drained();
    while (pending_samples.size() > 0 || in_tvalid || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic signed [POS_W-1:0] clamp_pos(int v);
    if (v > 8388607) return 24'sh7FFFFF;
    if (v < -8388608) return 24'sh800000;
    return v[POS_W-1:0];
  endfunction

  // mostly noisy tracks around a held point, some raw full-range samples
  task automatic queue_random(input int count);
    int      cx, cy, cz, spread, left;
    sample_t smp;
    left = 0;
    repeat (count) begin
      if (left == 0) begin
        cx = $urandom_range(0, 16777215) - 8388608;
        cy = $urandom_range(0, 16777215) - 8388608;
        cz = $urandom_range(0, 16777215) - 8388608;
        spread = (1 << $urandom_range(0, 14)) - 1;
        left = $urandom_range(20, 60);
      end
      left--;
      if ($urandom_range(0, 9) < 8) begin
        smp.pos_x = clamp_pos(cx + int'($urandom_range(0, 2 * spread)) - spread);
        smp.pos_y = clamp_pos(cy + int'($urandom_range(0, 2 * spread)) - spread);
        smp.pos_z = clamp_pos(cz + int'($urandom_range(0, 2 * spread)) - spread);
      end else begin
        smp.pos_x = POS_W'($urandom());
        smp.pos_y = POS_W'($urandom());
        smp.pos_z = POS_W'($urandom());
      end
      pending_samples = {pending_samples, smp};
    end
  endtask

  initial begin
    sample_t smp;
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    threshold  = THR_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset threshold: fill with a still point at the extremes, then swing hard
    smp.pos_x = 24'sh7FFFFF; smp.pos_y = 24'sh800000; smp.pos_z = '0;
    repeat (WIN) pending_samples = {pending_samples, smp};
    for (int i = 0; i < 10; i++) begin
      smp.pos_x = i[0] ? 24'sh800000 : 24'sh7FFFFF;
      smp.pos_y = i[0] ? 24'sh7FFFFF : 24'sh800000;
      smp.pos_z = i[0] ? 24'sh000001 : 24'shFFFFFF;
      pending_samples = {pending_samples, smp};
    end
    queue_random(80);
    wait_drained();

    // zero threshold is never stable
    write_threshold('0);
    smp = '0;
    repeat (5) pending_samples = {pending_samples, smp};
    queue_random(60);
    wait_drained();

    write_threshold('1);
    queue_random(80);
    wait_drained();

    write_threshold($urandom_range(0, 1 << 26));
    queue_random(80);
    wait_drained();

    write_threshold(32'd1);
    no_idle = 1;
    queue_random(80);
    while (pending_samples.size() > 0 || in_tvalid || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (error_count == 0) begin
      $display("window_variance_stability_detector_top verification clean");
    end else begin
      $display("window_variance_stability_detector_top verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/wvsd_pkg.sv
design/wvsd_ram.sv
design/wvsd_mul.sv
design/wvsd_div.sv
design/window_variance_stability_detector_top.sv
tb/window_variance_stability_detector_top_test.sv
